// ----- hdl/fpsc_pkg.sv -----
// ----------------------------------------------------------------------------
// Frustum cull package
// Operation codes, field widths and the plane construction tables.
// ----------------------------------------------------------------------------
package fpsc_pkg;

  localparam int FPSC_PLANES = 6;
  localparam int SCALE_W     = 11;
  localparam int CEN_W       = 21;
  localparam int RAD_W       = 31;
  localparam int VAL_W       = 32;
  localparam int OFF_W       = 48;
  localparam int WIDE_W      = 64;
  localparam int ROOT_W      = 32;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_TEST    = 2'd2;
  // The spare code is accepted and ignored.
  localparam logic [1:0] OP_SPARE   = 2'd3;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 11'd32;

  typedef logic signed [VAL_W-1:0] val_t;

  // Matrix column combined with column three for each plane.
  function automatic logic [1:0] plane_col(input logic [2:0] p);
    logic [1:0] c;
    case (p)
      3'd0, 3'd1: c = 2'd2;
      3'd2, 3'd3: c = 2'd0;
      default:    c = 2'd1;
    endcase
    return c;
  endfunction

  // High when the plane subtracts its column rather than adding it.
  function automatic logic plane_sub(input logic [2:0] p);
    return (p == 3'd1) || (p == 3'd3) || (p == 3'd4);
  endfunction

endpackage

// ----- hdl/fpsc_if.sv -----
// ----------------------------------------------------------------------------
// Frustum cull channels
// Ready/valid interfaces for the operation words and the result words.
// ----------------------------------------------------------------------------
interface fpsc_in_if;
  import fpsc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                operation;
  logic [3:0]                matrix_index;
  logic signed [VAL_W-1:0]   matrix_value;
  logic signed [CEN_W-1:0]   center_x;
  logic signed [CEN_W-1:0]   center_y;
  logic signed [CEN_W-1:0]   center_z;
  logic [RAD_W-1:0]          radius;
  modport source (output valid, operation, matrix_index, matrix_value,
                  center_x, center_y, center_z, radius, input ready);
  modport sink   (input valid, operation, matrix_index, matrix_value,
                  center_x, center_y, center_z, radius, output ready);
endinterface

interface fpsc_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

// ----- hdl/fpsc_sqrt.sv -----
// ----------------------------------------------------------------------------
// Frustum cull square root
// Bit-pair restoring integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module fpsc_sqrt import fpsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WIDE_W-1:0] radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [WIDE_W-1:0] rem_r, res_r, bit_r;
  logic              busy_r, done_r;
  logic [WIDE_W-1:0] trial;

  assign trial = res_r + bit_r;
  assign done  = done_r;
  assign root  = res_r[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= radicand;
        res_r  <= '0;
        bit_r  <= WIDE_W'(1) << (WIDE_W - 2);
      end else if (busy_r) begin
        if (rem_r >= trial) begin
          rem_r <= rem_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r == WIDE_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/fpsc_div.sv -----
// ----------------------------------------------------------------------------
// Frustum cull divider
// Signed by unsigned restoring division, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module fpsc_div import fpsc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [WIDE_W-1:0] numer,
  input  logic [ROOT_W-1:0]        denom,
  output logic                     done,
  output logic signed [WIDE_W-1:0] quot
);

  localparam int CNT_W = $clog2(WIDE_W + 1);

  logic [WIDE_W-1:0] mag_r;
  logic [ROOT_W-1:0] rem_r, den_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              neg_r, busy_r, done_r;
  logic [ROOT_W:0]   trial;
  logic              fits;

  assign trial = {rem_r, mag_r[WIDE_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign done  = done_r;
  assign quot  = neg_r ? -$signed(mag_r) : $signed(mag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        neg_r  <= numer[WIDE_W-1];
        mag_r  <= numer[WIDE_W-1] ? WIDE_W'(-numer) : WIDE_W'(numer);
        rem_r  <= '0;
        den_r  <= denom;
        cnt_r  <= CNT_W'(WIDE_W);
      end else if (busy_r) begin
        rem_r <= fits ? ROOT_W'(trial - {1'b0, den_r}) : trial[ROOT_W-1:0];
        mag_r <= {mag_r[WIDE_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/frustum_plane_extract_sphere_cull.sv -----
// ----------------------------------------------------------------------------
// Frustum plane extraction and sphere cull
// Holds a 4x4 matrix and six normalised planes; tests spheres against them.
// ----------------------------------------------------------------------------
// Operation words arrive on in_ch: a write stores one matrix element, an
// extract rebuilds all six planes, and a test produces one result word on
// out_ch. The block takes one word at a time and is not ready while a word
// is at work. All multiplications go through one shared 32x32 multiplier
// with a registered product, sequenced by a small state machine.
// A test scales the centre with three multiplies, then per plane does three
// multiply-accumulates and the distance compare, then loads the result word.
// An extract does per plane the column sums, the squares, a 32-step square
// root and four 64-step divisions; a zero-length normal skips the divisions.
// After reset the matrix and planes are zero and chunk_scale is 32.
// A finished result waits in the output register; while the receiver stalls
// a following write or extract still proceeds, and a test waits at its end.
// cfg_we writes chunk_scale and is to be used only while the block is idle;
// the user keeps to this, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module frustum_plane_extract_sphere_cull import fpsc_pkg::*; #(
  parameter int PLANE_COUNT = FPSC_PLANES
) (
  input  logic               clk,
  input  logic               rst_n,
  fpsc_in_if.sink            in_ch,
  fpsc_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [SCALE_W-1:0] cfg_data
);

  localparam int PW   = $clog2(PLANE_COUNT);
  localparam int NRMS = 3 * PLANE_COUNT;
  localparam int NW   = $clog2(NRMS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PT   = 4'd1;
  localparam logic [3:0] S_PTW  = 4'd2;
  localparam logic [3:0] S_MAC  = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_DIST = 4'd5;
  localparam logic [3:0] S_RES  = 4'd6;
  localparam logic [3:0] S_XA   = 4'd7;
  localparam logic [3:0] S_XB   = 4'd8;
  localparam logic [3:0] S_SQ   = 4'd9;
  localparam logic [3:0] S_SQA  = 4'd10;
  localparam logic [3:0] S_SQRT = 4'd11;
  localparam logic [3:0] S_SQW  = 4'd12;
  localparam logic [3:0] S_DIV  = 4'd13;
  localparam logic [3:0] S_DIVW = 4'd14;

  logic [3:0]                state_r;
  logic [PW-1:0]             p_r;
  logic [1:0]                k_r;
  logic [SCALE_W-1:0]        scale_r;
  logic signed [CEN_W-1:0]   cen_r [3];
  logic [RAD_W-1:0]          rad_r;
  val_t                      pt_r  [3];
  val_t                      raw_r [4];
  val_t                      a_r;
  val_t                      mat_r [16];
  val_t                      nrm_r [NRMS];
  logic signed [OFF_W-1:0]   off_r [PLANE_COUNT];
  logic signed [WIDE_W-1:0]  mul_r, acc_r;
  logic [WIDE_W-1:0]         sqs_r;
  logic signed [OFF_W-1:0]   best_r;
  logic                      out_valid_r, out_res_r;

  logic                      accept;
  val_t                      mul_a, mul_b;
  logic [NW-1:0]             nidx;
  logic [2:0]                pl;
  logic [3:0]                bidx;
  logic signed [VAL_W:0]     xsum;
  val_t                      xsat;
  logic signed [49:0]        shv;
  logic signed [50:0]        dsum;
  logic signed [OFF_W-1:0]   pdist;
  logic signed [OFF_W:0]     fin;
  logic                      last_plane;
  logic                      sq_start, sq_done;
  logic [ROOT_W-1:0]         root;
  logic                      dv_start, dv_done;
  logic signed [WIDE_W-1:0]  dv_num, quot;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.inside_res = out_res_r;

  assign pl         = 3'(p_r);
  assign nidx       = NW'(p_r * 3) + NW'(k_r);
  assign last_plane = (p_r == PW'(PLANE_COUNT - 1));
  assign bidx       = {k_r, plane_col(pl)};

  // Shared multiplier operands.
  always_comb begin
    case (state_r)
      S_PT: begin
        mul_a = val_t'(cen_r[k_r]);
        mul_b = val_t'({1'b0, scale_r});
      end
      S_MAC: begin
        mul_a = pt_r[k_r];
        mul_b = nrm_r[nidx];
      end
      S_SQ: begin
        mul_a = raw_r[k_r];
        mul_b = raw_r[k_r];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Raw plane component, saturated to Q16.16.
  always_comb begin
    if (plane_sub(pl)) xsum = (VAL_W+1)'(a_r) - (VAL_W+1)'(mat_r[bidx]);
    else               xsum = (VAL_W+1)'(a_r) + (VAL_W+1)'(mat_r[bidx]);
    if (xsum > (VAL_W+1)'(32'sh7fffffff))       xsat = 32'sh7fffffff;
    else if (xsum < -(VAL_W+1)'(33'sh080000000)) xsat = 32'sh80000000;
    else                                         xsat = xsum[VAL_W-1:0];
  end

  // Plane distance: floor to Q.16, add offset, saturate to 48 bits.
  always_comb begin
    shv  = 50'(acc_r >>> 14);
    dsum = 51'(shv) + 51'(off_r[p_r]);
    if (dsum > 51'sh7fffffffffff)        pdist = 48'sh7fffffffffff;
    else if (dsum < -51'sh800000000000)  pdist = 48'sh800000000000;
    else                                 pdist = dsum[OFF_W-1:0];
  end

  assign fin = (OFF_W+1)'(best_r) + $signed({18'd0, rad_r});

  assign sq_start = (state_r == S_SQRT);
  assign dv_start = (state_r == S_DIV);
  assign dv_num   = (k_r == 2'd3) ? (WIDE_W'(raw_r[3]) <<< 16)
                                  : (WIDE_W'(raw_r[k_r]) <<< 30);

  fpsc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sqs_r),
    .done     (sq_done),
    .root     (root)
  );

  fpsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .numer (dv_num),
    .denom (root),
    .done  (dv_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      p_r         <= '0;
      k_r         <= '0;
      scale_r     <= SCALE_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 16; i++) mat_r[i] <= '0;
      for (int i = 0; i < NRMS; i++) nrm_r[i] <= '0;
      for (int i = 0; i < PLANE_COUNT; i++) off_r[i] <= '0;
    end else begin
      if (cfg_we) scale_r <= cfg_data;
      if (out_valid_r && out_ch.ready && state_r != S_RES) out_valid_r <= 1'b0;
      mul_r <= mul_a * mul_b;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            p_r <= '0;
            k_r <= '0;
            case (in_ch.operation)
              OP_WRITE:   mat_r[in_ch.matrix_index] <= in_ch.matrix_value;
              OP_EXTRACT: state_r <= S_XA;
              OP_TEST: begin
                cen_r[0] <= in_ch.center_x;
                cen_r[1] <= in_ch.center_y;
                cen_r[2] <= in_ch.center_z;
                rad_r    <= in_ch.radius;
                state_r  <= S_PT;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_PT: state_r <= S_PTW;
        S_PTW: begin
          pt_r[k_r] <= mul_r[VAL_W-1:0];
          if (k_r == 2'd2) begin
            k_r     <= '0;
            state_r <= S_MAC;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_PT;
          end
        end
        S_MAC: state_r <= S_ACC;
        S_ACC: begin
          acc_r <= ((k_r == 2'd0) ? '0 : acc_r) + mul_r;
          if (k_r == 2'd2) begin
            k_r     <= '0;
            state_r <= S_DIST;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_MAC;
          end
        end
        S_DIST: begin
          if (p_r == '0 || pdist < best_r) best_r <= pdist;
          if (last_plane) begin
            state_r <= S_RES;
          end else begin
            p_r     <= p_r + 1'b1;
            state_r <= S_MAC;
          end
        end
        S_RES: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_res_r   <= (fin > 49'sd0);
            state_r     <= S_IDLE;
          end
        end
        S_XA: begin
          a_r     <= mat_r[{k_r, 2'd3}];
          state_r <= S_XB;
        end
        S_XB: begin
          raw_r[k_r] <= xsat;
          k_r        <= k_r + 1'b1;
          state_r    <= (k_r == 2'd3) ? S_SQ : S_XA;
        end
        S_SQ: state_r <= S_SQA;
        S_SQA: begin
          sqs_r <= ((k_r == 2'd0) ? '0 : sqs_r) + WIDE_W'(mul_r);
          if (k_r == 2'd2) begin
            k_r     <= '0;
            state_r <= S_SQRT;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_SQ;
          end
        end
        S_SQRT: state_r <= S_SQW;
        S_SQW: begin
          if (sq_done) begin
            k_r <= '0;
            if (root == '0) begin
              // A zero-length normal leaves the plane unnormalised.
              for (int j = 0; j < 3; j++) nrm_r[NW'(p_r * 3) + NW'(j)] <= '0;
              off_r[p_r] <= OFF_W'(raw_r[3]);
              p_r        <= last_plane ? '0 : p_r + 1'b1;
              state_r    <= last_plane ? S_IDLE : S_XA;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: state_r <= S_DIVW;
        S_DIVW: begin
          if (dv_done) begin
            if (k_r == 2'd3) begin
              off_r[p_r] <= quot[OFF_W-1:0];
              k_r        <= '0;
              p_r        <= last_plane ? '0 : p_r + 1'b1;
              state_r    <= last_plane ? S_IDLE : S_XA;
            end else begin
              nrm_r[nidx] <= quot[VAL_W-1:0];
              k_r         <= k_r + 1'b1;
              state_r     <= S_DIV;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> state_r == S_SQW)
    else $error("square root finished outside its wait state");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    dv_done |-> state_r == S_DIVW)
    else $error("division finished outside its wait state");

  a_test_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.operation == OP_TEST) |=> state_r == S_PT)
    else $error("accepted test word did not start the centre scaling");

  a_res_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RES && $past(state_r) == S_DIST) |-> p_r == PW'(PLANE_COUNT - 1))
    else $error("result stage reached before the last plane");

endmodule

// ----- tb/sv/frustum_cull_checker.sv -----
// ----------------------------------------------------------------------------
// Frustum cull checker
// Watches the operation and result channels, keeps its own copy of the matrix,
// the planes and chunk_scale, predicts each cull verdict and compares it with
// the result word that the block delivers.
// ----------------------------------------------------------------------------
module frustum_cull_checker import fpsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  fpsc_in_if                 in_mon,
  fpsc_out_if                out_mon,
  input  logic               cfg_we,
  input  logic [SCALE_W-1:0] cfg_data,
  output int                 errors,
  output int                 pending
);

  localparam longint SAT48_HI = (longint'(1) <<< 47) - 1;
  localparam longint SAT48_LO = -SAT48_HI - 1;

  logic [SCALE_W-1:0] scale_copy;
  longint             mat[16];
  longint             nrm[FPSC_PLANES*3];
  longint             offs[FPSC_PLANES];
  bit                 inside_due[$];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp48(input longint v);
    if (v > SAT48_HI) return SAT48_HI;
    if (v < SAT48_LO) return SAT48_LO;
    return v;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned s);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Rebuilds the six planes from column three and the plane's own column.
  task automatic rebuild_planes();
    longint raw[4];
    longint unsigned sq;
    longint len;
    int col;
    bit sub;
    for (int p = 0; p < FPSC_PLANES; p++) begin
      case (p)
        0, 1:    col = 2;
        2, 3:    col = 0;
        default: col = 1;
      endcase
      sub = (p == 1) || (p == 3) || (p == 4);
      for (int r = 0; r < 4; r++)
        raw[r] = clamp32(sub ? mat[4*r+3] - mat[4*r+col] : mat[4*r+3] + mat[4*r+col]);
      sq = 0;
      for (int k = 0; k < 3; k++) sq = sq + longint'(raw[k] * raw[k]);
      len = longint'(root_floor(sq));
      if (len == 0) begin
        for (int k = 0; k < 3; k++) nrm[3*p+k] = 0;
        offs[p] = raw[3];
      end else begin
        for (int k = 0; k < 3; k++)
          nrm[3*p+k] = longint'(int'((raw[k] * 64'sd1073741824) / len));
        offs[p] = clamp48((raw[3] * 64'sd65536) / len);
      end
    end
  endtask

  function automatic bit cull_verdict(input logic signed [CEN_W-1:0] cx,
                                      input logic signed [CEN_W-1:0] cy,
                                      input logic signed [CEN_W-1:0] cz,
                                      input logic [RAD_W-1:0] rad);
    longint pt[3];
    longint acc;
    longint d;
    longint best;
    longint sc;
    sc = longint'({53'd0, scale_copy});
    pt[0] = longint'(cx) * sc;
    pt[1] = longint'(cy) * sc;
    pt[2] = longint'(cz) * sc;
    best = 0;
    for (int p = 0; p < FPSC_PLANES; p++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc = acc + pt[k] * nrm[3*p+k];
      d = clamp48((acc >>> 14) + offs[p]);
      if (p == 0 || d < best) best = d;
    end
    return (best + longint'({33'd0, rad})) > 0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      scale_copy = SCALE_RESET;
      for (int i = 0; i < 16; i++) mat[i] = 0;
      for (int i = 0; i < FPSC_PLANES*3; i++) nrm[i] = 0;
      for (int i = 0; i < FPSC_PLANES; i++) offs[i] = 0;
      inside_due.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) scale_copy = cfg_data;
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.operation)
          OP_WRITE:   mat[in_mon.matrix_index] = longint'(in_mon.matrix_value);
          OP_EXTRACT: rebuild_planes();
          OP_TEST:    inside_due.push_back(cull_verdict(in_mon.center_x,
                        in_mon.center_y, in_mon.center_z, in_mon.radius));
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (inside_due.size() == 0) begin
          $display("%0t: unexpected result word, actual inside_res=%0b",
                   $time, out_mon.inside_res);
          errors <= errors + 1;
        end else if (inside_due[0] !== out_mon.inside_res) begin
          $display("%0t: inside_res mismatch, expected %0b actual %0b",
                   $time, inside_due[0], out_mon.inside_res);
          errors <= errors + 1;
          void'(inside_due.pop_front());
        end else begin
          void'(inside_due.pop_front());
        end
      end
      pending <= inside_due.size();
    end
  end

endmodule

// ----- tb/sv/frustum_plane_extract_sphere_cull_test.sv -----
// ----------------------------------------------------------------------------
// Frustum cull testbench
// Drives directed and random operation words through the cull block under
// random idling, random stalls and one long hold-off over several chunk_scale
// settings; the checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module frustum_plane_extract_sphere_cull_test;
  import fpsc_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_WAIT  = 2500;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [SCALE_W-1:0] cfg_data;
  int                 errors;
  int                 pending;
  int                 cycles;
  int                 issued;
  bit                 calm;
  bit                 hold_go;
  bit                 hold_seen;
  int                 hold_left;

  fpsc_in_if  in_ch ();
  fpsc_out_if out_ch ();

  frustum_plane_extract_sphere_cull uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  frustum_cull_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("frustum_plane_extract_sphere_cull test failed");
      $finish;
    end
  end

  // Result side: random stalls, and one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_go && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 14);
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [3:0] idx,
                           input logic [31:0] val, input logic [20:0] cx,
                           input logic [20:0] cy, input logic [20:0] cz,
                           input logic [30:0] rad);
    int gap;
    if (!calm && $urandom_range(99) < 14) begin
      gap = $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.matrix_index <= idx;
    in_ch.matrix_value <= val;
    in_ch.center_x     <= cx;
    in_ch.center_y     <= cy;
    in_ch.center_z     <= cz;
    in_ch.radius       <= rad;
    do @(posedge clk); while (!in_ch.ready);
    if (op != OP_SPARE) issued++;
  endtask

  task automatic put_elem(input logic [3:0] idx, input logic [31:0] val);
    send_word(OP_WRITE, idx, val, 21'($urandom), 21'($urandom), 21'($urandom),
              31'($urandom));
  endtask

  task automatic probe(input logic [20:0] cx, input logic [20:0] cy,
                       input logic [20:0] cz, input logic [30:0] rad);
    send_word(OP_TEST, 4'($urandom), $urandom, cx, cy, cz, rad);
  endtask

  // Waits for every result, lets a possible extract finish, then writes.
  task automatic set_scale(input logic [SCALE_W-1:0] s);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= s;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [31:0] mid_value();
    if ($urandom_range(9) == 0) return $urandom;
    return 32'($urandom_range(0, 262144)) - 32'd131072;
  endfunction

  function automatic logic [20:0] pick_centre();
    if ($urandom_range(7) == 0) return 21'($urandom);
    return 21'($urandom_range(0, 200)) - 21'd100;
  endfunction

  function automatic logic [30:0] pick_radius();
    case ($urandom_range(3))
      0:       return 31'($urandom);
      1:       return 31'd0;
      default: return 31'($urandom_range(0, 32'h0100_0000));
    endcase
  endfunction

  // One frame: element writes, an extract, then tests mixed with random words.
  task automatic run_frame();
    int n;
    n = $urandom_range(0, 16);
    repeat (n) put_elem(4'($urandom), mid_value());
    send_word(OP_EXTRACT, 4'($urandom), $urandom, 21'($urandom), 21'($urandom),
              21'($urandom), 31'($urandom));
    n = $urandom_range(5, 25);
    repeat (n) begin
      if ($urandom_range(9) == 0)
        send_word(2'($urandom), 4'($urandom), $urandom, 21'($urandom),
                  21'($urandom), 21'($urandom), 31'($urandom));
      else
        probe(pick_centre(), pick_centre(), pick_centre(), pick_radius());
    end
  endtask

  initial begin
    logic [SCALE_W-1:0] scales[6];
    issued = 0;
    calm = 1'b0;
    hold_go = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_data <= SCALE_RESET;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_WRITE;
    in_ch.matrix_index <= '0;
    in_ch.matrix_value <= '0;
    in_ch.center_x <= '0;
    in_ch.center_y <= '0;
    in_ch.center_z <= '0;
    in_ch.radius <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Before any extract the planes are zero: the verdict is radius above zero.
    probe(21'd0, 21'd0, 21'd0, 31'd0);
    probe(21'h0FFFFF, 21'h100000, 21'd5, 31'd1);
    send_word(OP_SPARE, 4'd15, 32'hFFFF_FFFF, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF,
              31'h7FFF_FFFF);
    // Only m33 set: every normal has zero length and keeps its raw offset.
    put_elem(4'd15, 32'h0001_0000);
    send_word(OP_EXTRACT, 4'd0, 32'd0, 21'd0, 21'd0, 21'd0, 31'd0);
    probe(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF, 31'd0);
    put_elem(4'd0, 32'h0001_0000);
    put_elem(4'd5, 32'h0001_0000);
    put_elem(4'd10, 32'h0001_0000);
    send_word(OP_EXTRACT, 4'd0, 32'd0, 21'd0, 21'd0, 21'd0, 31'd0);
    probe(21'd0, 21'd0, 21'd0, 31'd0);
    probe(21'h0FFFFF, 21'd0, 21'd0, 31'd0);
    probe(21'h100000, 21'h100000, 21'h100000, 31'h7FFF_FFFF);
    probe(21'd1, 21'd0, 21'd0, 31'd0);
    // Extreme elements saturate the column sums.
    put_elem(4'd3, 32'h7FFF_FFFF);
    put_elem(4'd0, 32'h7FFF_FFFF);
    put_elem(4'd7, 32'h8000_0000);
    put_elem(4'd4, 32'h8000_0000);
    send_word(OP_EXTRACT, 4'd0, 32'd0, 21'd0, 21'd0, 21'd0, 31'd0);
    probe(21'h0FFFFF, 21'h100000, 21'h0FFFFF, 31'h7FFF_FFFF);
    probe(21'h100000, 21'h0FFFFF, 21'h100000, 31'd0);

    scales[0] = 11'd1;
    scales[1] = 11'd1024;
    scales[2] = 11'd2047;
    scales[3] = 11'd0;
    scales[4] = 11'($urandom_range(1, 1024));
    scales[5] = SCALE_RESET;
    for (int ph = 0; ph < 6; ph++) begin
      set_scale(scales[ph]);
      while (issued < 270 * (ph + 1)) begin
        calm = (ph == 2);
        if (ph == 1 && !hold_go && issued > 400) hold_go = 1'b1;
        run_frame();
      end
      calm = 1'b0;
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("frustum_plane_extract_sphere_cull test passed");
    else
      $display("frustum_plane_extract_sphere_cull test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/fpsc_pkg.sv
hdl/fpsc_if.sv
hdl/fpsc_sqrt.sv
hdl/fpsc_div.sv
hdl/frustum_plane_extract_sphere_cull.sv
tb/sv/frustum_cull_checker.sv
tb/sv/frustum_plane_extract_sphere_cull_test.sv
